/* rtl/ascon_pkg.sv */
// Shared types, command codes and permutation functions of the Ascon-128 AEAD core.
// No dependencies; imported by every module of the core and by its checker.
package ascon_pkg;

   localparam int unsigned LaneW  = 64;
   localparam int unsigned Lanes  = 5;
   localparam int unsigned Rounds = 12;
   localparam int unsigned RndW   = $clog2(Rounds);

   localparam logic [LaneW-1:0] IV_WORD = 64'h80400c0600000000;

   localparam logic [2:0] CMD_INIT     = 3'd0;
   localparam logic [2:0] CMD_ASSOC    = 3'd1;
   localparam logic [2:0] CMD_ENCRYPT  = 3'd2;
   localparam logic [2:0] CMD_DECRYPT  = 3'd3;
   localparam logic [2:0] CMD_FINALIZE = 3'd4;

   localparam logic [RndW-1:0] RND_FULL  = RndW'(0);
   localparam logic [RndW-1:0] RND_HALF  = RndW'(6);
   localparam logic [RndW-1:0] RND_LAST  = RndW'(Rounds - 1);

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_TAG  = 1'b1;

   typedef logic [Lanes-1:0][LaneW-1:0] state_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINISH
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic round;
      logic finish;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic assoc_closed;
      logic data_seen;
      logic last_round;
      logic has_result;
      logic out_free;
   } dp_stat_type;

   function automatic logic [LaneW-1:0] round_const(input logic [RndW-1:0] idx);
      logic [LaneW-1:0] c;
      unique case (idx)
         4'd0:    c = 64'hf0;
         4'd1:    c = 64'he1;
         4'd2:    c = 64'hd2;
         4'd3:    c = 64'hc3;
         4'd4:    c = 64'hb4;
         4'd5:    c = 64'ha5;
         4'd6:    c = 64'h96;
         4'd7:    c = 64'h87;
         4'd8:    c = 64'h78;
         4'd9:    c = 64'h69;
         4'd10:   c = 64'h5a;
         4'd11:   c = 64'h4b;
         default: c = '0;
      endcase
      return c;
   endfunction

   function automatic logic [LaneW-1:0] rotr(input logic [LaneW-1:0] v, input int unsigned n);
      return (v >> n) | (v << (LaneW - n));
   endfunction

   // One permutation round: constant addition, substitution layer, linear layer.
   function automatic state_type perm_round(input state_type s, input logic [LaneW-1:0] c);
      logic [LaneW-1:0] x0, x1, x2, x3, x4;
      logic [LaneW-1:0] t0, t1, t2, t3, t4;
      state_type        r;
      x0 = s[0]; x1 = s[1]; x2 = s[2] ^ c; x3 = s[3]; x4 = s[4];
      x0 = x0 ^ x4; x4 = x4 ^ x3; x2 = x2 ^ x1;
      t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
      x0 = x0 ^ t1; x1 = x1 ^ t2; x2 = x2 ^ t3; x3 = x3 ^ t4; x4 = x4 ^ t0;
      x1 = x1 ^ x0; x0 = x0 ^ x4; x3 = x3 ^ x2; x2 = ~x2;
      r[0] = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
      r[1] = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
      r[2] = x2 ^ rotr(x2, 1)  ^ rotr(x2, 6);
      r[3] = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
      r[4] = x4 ^ rotr(x4, 7)  ^ rotr(x4, 41);
      return r;
   endfunction

endpackage

/* rtl/ascon_ctrl.sv */
// Sequencer of the Ascon core: decides per transaction which steps the datapath runs.
// Depends on ascon_pkg.
module ascon_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [2:0]             req_cmd,
   output logic                   req_stall,
   input  ascon_pkg::dp_stat_type stat,
   output ascon_pkg::dp_cmd_type  cmd
);
   import ascon_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           take;
   logic           drop;
   logic           skip_rounds;

   assign take = req_valid && (state_ff == ST_IDLE);

   // unknown codes and associated data after the phase closed leave everything alone
   assign drop = (req_cmd > CMD_FINALIZE) || ((req_cmd == CMD_ASSOC) && stat.assoc_closed);

   // the first data block goes straight to the output step
   assign skip_rounds = ((req_cmd == CMD_ENCRYPT) || (req_cmd == CMD_DECRYPT)) &&
                        !stat.data_seen;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take && !drop) begin
               state_in = skip_rounds ? ST_FINISH : ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (stat.last_round) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!stat.has_result || stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = (state_ff != ST_IDLE);
      cmd.load   = take && !drop;
      cmd.round  = (state_ff == ST_ROUND);
      cmd.finish = (state_ff == ST_FINISH) && (!stat.has_result || stat.out_free);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/ascon_dp.sv */
// Datapath of the Ascon core: state lanes, round unit, phase flags and result register.
// Depends on ascon_pkg.
module ascon_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  ascon_pkg::dp_cmd_type  cmd,
   output ascon_pkg::dp_stat_type stat,
   input  logic [2:0]             req_cmd,
   input  logic [63:0]            req_word_a,
   input  logic [63:0]            req_word_b,
   input  logic [63:0]            key_high,
   input  logic [63:0]            key_low,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_out_kind,
   output logic [63:0]            rsp_out_word_a,
   output logic [63:0]            rsp_out_word_b,
   output logic                   rsp_tag_match
);
   import ascon_pkg::*;

   state_type        lanes_ff, lanes_in;
   logic             closed_ff, closed_in;
   logic             seen_ff, seen_in;
   logic [RndW-1:0]  rnd_ff, rnd_in;
   logic [2:0]       op_ff;
   logic [LaneW-1:0] wa_ff, wb_ff;
   logic             vld_ff, vld_in;
   logic             kind_ff;
   logic [LaneW-1:0] outa_ff, outb_ff;
   logic             match_ff;
   logic [LaneW-1:0] blk;
   logic [LaneW-1:0] tag_a, tag_b;
   logic             is_data;

   assign is_data = (op_ff == CMD_ENCRYPT) || (op_ff == CMD_DECRYPT);
   assign blk     = wa_ff ^ lanes_ff[0];
   assign tag_a   = lanes_ff[3] ^ key_high;
   assign tag_b   = lanes_ff[4] ^ key_low;

   always_comb begin
      lanes_in  = lanes_ff;
      closed_in = closed_ff;
      seen_in   = seen_ff;
      rnd_in    = rnd_ff;
      if (cmd.load) begin
         unique case (req_cmd)
            CMD_INIT: begin
               lanes_in  = {req_word_b, req_word_a, key_low, key_high, IV_WORD};
               closed_in = 1'b0;
               seen_in   = 1'b0;
               rnd_in    = RND_FULL;
            end
            CMD_ASSOC: begin
               lanes_in[0] = lanes_ff[0] ^ req_word_a;
               rnd_in      = RND_HALF;
            end
            CMD_FINALIZE: begin
               lanes_in[1] = lanes_ff[1] ^ key_high;
               lanes_in[2] = lanes_ff[2] ^ key_low;
               lanes_in[4] = lanes_ff[4] ^ {{(LaneW-1){1'b0}}, !closed_ff};
               closed_in   = 1'b1;
               rnd_in      = RND_FULL;
            end
            default: begin
               lanes_in[4] = lanes_ff[4] ^ {{(LaneW-1){1'b0}}, !closed_ff};
               closed_in   = 1'b1;
               rnd_in      = RND_HALF;
            end
         endcase
      end else if (cmd.round) begin
         lanes_in = perm_round(lanes_ff, round_const(rnd_ff));
         rnd_in   = rnd_ff + RndW'(1);
      end else if (cmd.finish) begin
         if ((op_ff == CMD_INIT) || (op_ff == CMD_FINALIZE)) begin
            lanes_in[3] = tag_a;
            lanes_in[4] = tag_b;
         end else if (is_data) begin
            lanes_in[0] = (op_ff == CMD_ENCRYPT) ? blk : wa_ff;
            seen_in     = 1'b1;
         end
      end
   end

   // result register: load on a finishing data or tag step, drop once taken
   assign vld_in = (cmd.finish && (is_data || (op_ff == CMD_FINALIZE))) ||
                   (vld_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         lanes_ff  <= '0;
         closed_ff <= 1'b0;
         seen_ff   <= 1'b0;
         vld_ff    <= 1'b0;
      end else begin
         lanes_ff  <= lanes_in;
         closed_ff <= closed_in;
         seen_ff   <= seen_in;
         vld_ff    <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
      if (cmd.load) begin
         op_ff <= req_cmd;
         wa_ff <= req_word_a;
         wb_ff <= req_word_b;
      end
      if (cmd.finish && is_data) begin
         kind_ff  <= KIND_DATA;
         outa_ff  <= blk;
         outb_ff  <= '0;
         match_ff <= 1'b0;
      end else if (cmd.finish && (op_ff == CMD_FINALIZE)) begin
         kind_ff  <= KIND_TAG;
         outa_ff  <= tag_a;
         outb_ff  <= tag_b;
         match_ff <= (tag_a == wa_ff) && (tag_b == wb_ff);
      end
   end

   always_comb begin
      stat.assoc_closed = closed_ff;
      stat.data_seen    = seen_ff;
      stat.last_round   = (rnd_ff == RND_LAST);
      stat.has_result   = is_data || (op_ff == CMD_FINALIZE);
      stat.out_free     = !vld_ff || !rsp_stall;
   end

   assign rsp_valid      = vld_ff;
   assign rsp_out_kind   = kind_ff;
   assign rsp_out_word_a = outa_ff;
   assign rsp_out_word_b = outb_ff;
   assign rsp_tag_match  = match_ff;

endmodule

/* rtl/ascon_aead_core.sv */
// Top level of the Ascon-128 AEAD core: key registers, APB-style port, sequencer and datapath.
// Depends on ascon_pkg, ascon_ctrl and ascon_dp.
//
// Usage
//   Write the key over the csr_ port (key_high at byte 0, key_low at byte 8, 64-bit data)
//   while the core is idle. Then send transactions on the req_ channel: init with the
//   nonce in word_a:word_b, associated blocks, encrypt or decrypt blocks, then finalize
//   with the expected tag. Encrypt, decrypt and finalize each return one transaction on
//   the rsp_ channel; init, associated blocks and unknown commands return nothing.
// Sequencing
//   The core works on one transaction at a time; the single round unit runs one round per
//   cycle. A transaction occupies the core for a load step, its rounds (12 for init and
//   finalize, 6 for associated blocks and later data blocks, none for the first data block)
//   and an output step. The result shows on rsp_ the cycle after the output step.
//   Dropped commands start no rounds and no output step.
// Reset
//   Synchronous reset clears the lanes, the phase flags, the keys and rsp_valid.
// Back-pressure
//   The result register holds while rsp_stall is high; the core still accepts the next
//   transaction and runs its rounds, holding only at its output step until the slot frees.
module ascon_aead_core (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [63:0] req_word_a,
   input  logic [63:0] req_word_b,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_out_kind,
   output logic [63:0] rsp_out_word_a,
   output logic [63:0] rsp_out_word_b,
   output logic        rsp_tag_match,
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);
   import ascon_pkg::*;

   logic [LaneW-1:0] key_high_ff;
   logic [LaneW-1:0] key_low_ff;
   logic             csr_wr;
   dp_cmd_type       dp_cmd;
   dp_stat_type      dp_stat;

   // Registers sit every 8 bytes; decode on address bit 3 alone.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = csr_paddr[3] ? key_low_ff : key_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_wr) begin
         if (csr_paddr[3]) begin
            key_low_ff <= csr_pwdata;
         end else begin
            key_high_ff <= csr_pwdata;
         end
      end
   end

   ascon_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (dp_stat),
      .cmd       (dp_cmd)
   );

   ascon_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (dp_cmd),
      .stat           (dp_stat),
      .req_cmd        (req_cmd),
      .req_word_a     (req_word_a),
      .req_word_b     (req_word_b),
      .key_high       (key_high_ff),
      .key_low        (key_low_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_word_a (rsp_out_word_a),
      .rsp_out_word_b (rsp_out_word_b),
      .rsp_tag_match  (rsp_tag_match)
   );

endmodule

/* rtl/ascon_chk.sv */
// Port-level checker of the Ascon core, bound to the top level.
// Depends on ascon_pkg and ascon_aead_core.
module ascon_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [2:0]  req_cmd,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_out_kind,
   input logic [63:0] rsp_out_word_a,
   input logic [63:0] rsp_out_word_b,
   input logic        rsp_tag_match
);
   import ascon_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_kind) &&
      $stable(rsp_out_word_a) && $stable(rsp_out_word_b) && $stable(rsp_tag_match))
      else $error("stalled response changed");

   // an init always keeps the core busy the next cycle
   a_init_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_cmd == CMD_INIT) |=> req_stall)
      else $error("core idle right after init");

   // data results carry no tag word and no match flag
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_out_kind == KIND_DATA) |-> (rsp_out_word_b == '0) && !rsp_tag_match)
      else $error("data response with tag fields set");

   // a new result only appears after a busy cycle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response without work");

endmodule

bind ascon_aead_core ascon_chk u_chk (.*);

/* bench/ascon_aead_checker.sv */
// Response checker for the Ascon-128 AEAD core: tracks key writes on the register port,
// predicts every response from accepted requests and compares it field by field.
// Depends on ascon_pkg only.
module ascon_aead_checker
   import ascon_pkg::*;
#(
   parameter logic [3:0] KeyHighAddr = 4'h0,
   parameter logic [3:0] KeyLowAddr  = 4'h8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_cmd,
   input  logic [63:0] req_word_a,
   input  logic [63:0] req_word_b,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_out_kind,
   input  logic [63:0] rsp_out_word_a,
   input  logic [63:0] rsp_out_word_b,
   input  logic        rsp_tag_match,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int          errors,
   output int          open_count
);

   typedef struct packed {
      logic        kind;
      logic [63:0] word_a;
      logic [63:0] word_b;
      logic        tag_ok;
   } response_rec;

   response_rec expected_responses[$];
   state_type   sponge;
   logic [63:0] key_hi;
   logic [63:0] key_lo;
   logic        ad_closed;
   logic        data_begun;
   int          fail_count;

   function automatic logic [63:0] ror(input logic [63:0] v, input int n);
      return (v >> n) | (v << (64 - n));
   endfunction

   // round r of the 12-round schedule; constants run f0, e1, ... 4b
   function automatic state_type sponge_round(input state_type s, input int r);
      logic [63:0] x0, x1, x2, x3, x4;
      logic [63:0] t0, t1, t2, t3, t4;
      state_type   o;
      x0 = s[0];
      x1 = s[1];
      x2 = s[2] ^ {56'd0, 4'(15 - r), 4'(r)};
      x3 = s[3];
      x4 = s[4];
      x0 ^= x4;
      x4 ^= x3;
      x2 ^= x1;
      t0 = ~x0 & x1;
      t1 = ~x1 & x2;
      t2 = ~x2 & x3;
      t3 = ~x3 & x4;
      t4 = ~x4 & x0;
      x0 ^= t1;
      x1 ^= t2;
      x2 ^= t3;
      x3 ^= t4;
      x4 ^= t0;
      x1 ^= x0;
      x0 ^= x4;
      x3 ^= x2;
      x2 = ~x2;
      o[0] = x0 ^ ror(x0, 19) ^ ror(x0, 28);
      o[1] = x1 ^ ror(x1, 61) ^ ror(x1, 39);
      o[2] = x2 ^ ror(x2, 1) ^ ror(x2, 6);
      o[3] = x3 ^ ror(x3, 10) ^ ror(x3, 17);
      o[4] = x4 ^ ror(x4, 7) ^ ror(x4, 41);
      return o;
   endfunction

   task automatic run_rounds(input int count);
      for (int r = int'(Rounds) - count; r < int'(Rounds); r++) begin
         sponge = sponge_round(sponge, r);
      end
   endtask

   task automatic close_assoc_phase();
      if (!ad_closed) begin
         sponge[4][0] = ~sponge[4][0];
         ad_closed = 1'b1;
      end
   endtask

   task automatic advance_cipher_state(input logic [2:0] cmd, input logic [63:0] a,
                                       input logic [63:0] b);
      logic [63:0] blk;
      case (cmd)
         CMD_INIT: begin
            sponge[0] = IV_WORD;
            sponge[1] = key_hi;
            sponge[2] = key_lo;
            sponge[3] = a;
            sponge[4] = b;
            run_rounds(int'(Rounds));
            sponge[3] ^= key_hi;
            sponge[4] ^= key_lo;
            ad_closed = 1'b0;
            data_begun = 1'b0;
         end
         CMD_ASSOC: begin
            if (!ad_closed) begin
               sponge[0] ^= a;
               run_rounds(int'(Rounds) / 2);
            end
         end
         CMD_ENCRYPT, CMD_DECRYPT: begin
            close_assoc_phase();
            if (data_begun) begin
               run_rounds(int'(Rounds) / 2);
            end
            blk = a ^ sponge[0];
            sponge[0] = (cmd == CMD_ENCRYPT) ? blk : a;
            data_begun = 1'b1;
            expected_responses.push_back('{KIND_DATA, blk, 64'd0, 1'b0});
         end
         CMD_FINALIZE: begin
            close_assoc_phase();
            sponge[1] ^= key_hi;
            sponge[2] ^= key_lo;
            run_rounds(int'(Rounds));
            sponge[3] ^= key_hi;
            sponge[4] ^= key_lo;
            expected_responses.push_back('{KIND_TAG, sponge[3], sponge[4],
                                          (sponge[3] == a) && (sponge[4] == b)});
         end
         default: begin
         end
      endcase
   endtask

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      response_rec want;
      if (reset) begin
         sponge = '0;
         key_hi = '0;
         key_lo = '0;
         ad_closed = 1'b0;
         data_begun = 1'b0;
         expected_responses.delete();
         fail_count = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == KeyHighAddr) begin
               key_hi = csr_pwdata;
            end else if (csr_paddr == KeyLowAddr) begin
               key_lo = csr_pwdata;
            end
         end
         // responses first: one accepted at this edge belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $error("response with none expected: kind %h, word_a %h",
                      rsp_out_kind, rsp_out_word_a);
               fail_count++;
            end else begin
               want = expected_responses.pop_front();
               compare_field("out_kind", 64'(want.kind), 64'(rsp_out_kind));
               compare_field("out_word_a", want.word_a, rsp_out_word_a);
               compare_field("out_word_b", want.word_b, rsp_out_word_b);
               compare_field("tag_match", 64'(want.tag_ok), 64'(rsp_tag_match));
            end
         end
         if (req_valid && !req_stall) begin
            advance_cipher_state(req_cmd, req_word_a, req_word_b);
         end
      end
      errors <= fail_count;
      open_count <= expected_responses.size();
   end

endmodule

/* bench/ascon_aead_core_tb.sv */
// Testbench top for the Ascon-128 AEAD core: clock, reset, key writes and request stimulus,
// a randomly stalling response sink and the final verdict. Depends on ascon_pkg,
// ascon_aead_core and ascon_aead_checker.
module ascon_aead_core_tb;
   import ascon_pkg::*;

   // register map: 64-bit registers at byte stride 8
   localparam logic [3:0] KEY_HIGH_ADDR = 4'h0;
   localparam logic [3:0] KEY_LOW_ADDR  = 4'h8;
   localparam logic [2:0] CMD_LAST_CODE = 3'h7;

   localparam int PHASE_ITEMS   = 300;
   localparam int PHASES        = 6;      // about 1800 random transactions in all
   localparam int MAX_GAP       = 13;
   localparam int SETTLE_CYCLES = 24;     // covers the longest transaction, an init or finalize, with its output
   localparam int LONG_HOLD     = 400;
   localparam int CYCLE_LIMIT   = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_cmd = CMD_INIT;
   logic [63:0] req_word_a = '0;
   logic [63:0] req_word_b = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_out_kind;
   logic [63:0] rsp_out_word_a;
   logic [63:0] rsp_out_word_b;
   logic        rsp_tag_match;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = KEY_HIGH_ADDR;
   logic [63:0] csr_pwdata = '0;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int          mismatches;
   int          awaiting;
   int          cycle_count = 0;
   int          sent = 0;
   int          sent_total = 0;
   int          key_loads = 0;
   int          taken = 0;
   int          tag_hits = 0;
   bit          calm = 1'b0;
   logic [63:0]  seen_blocks[$];
   logic [127:0] seen_tag = '0;

   ascon_aead_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_word_a     (req_word_a),
      .req_word_b     (req_word_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_word_a (rsp_out_word_a),
      .rsp_out_word_b (rsp_out_word_b),
      .rsp_tag_match  (rsp_tag_match),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   ascon_aead_checker #(
      .KeyHighAddr (KEY_HIGH_ADDR),
      .KeyLowAddr  (KEY_LOW_ADDR)
   ) tx_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_word_a     (req_word_a),
      .req_word_b     (req_word_b),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_out_word_a (rsp_out_word_a),
      .rsp_out_word_b (rsp_out_word_b),
      .rsp_tag_match  (rsp_tag_match),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .errors         (mismatches),
      .open_count     (awaiting)
   );

   always #5 clock = ~clock;

   // Abort a hung run; the limit sits several times above the slowest legal run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses outstanding", cycle_count, awaiting);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Idle cycles before the next transaction on either side; zero in calm phases.
   function automatic int pick_gap();
      return calm ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // Mostly random words, with the extremes drawn now and then.
   function automatic logic [63:0] rand_word();
      case ($urandom_range(0, 9))
         0: begin
            return '0;
         end
         1: begin
            return '1;
         end
         default: begin
            return {$urandom, $urandom};
         end
      endcase
   endfunction

   // Offer one request transaction after a random gap and hold it until accepted.
   // Valid stays high straight through when the gap is zero.
   task automatic send_item(input logic [2:0] cmd, input logic [63:0] a, input logic [63:0] b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_word_a <= a;
      req_word_b <= b;
      do @(posedge clock); while (req_stall);
      if (cmd <= CMD_FINALIZE) begin
         sent++;
         sent_total++;
      end
   endtask

   // Drop valid and wait until every predicted response has been taken. With settle set,
   // also let an init or associated block that returns nothing run to its end.
   task automatic drain(input bit settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      if (settle) begin
         repeat (settle ? SETTLE_CYCLES : 0) @(posedge clock);
      end
   endtask

   // Write both key words in one bus burst: setup then access for each, psel held
   // high across the pair.
   task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
      for (int i = 0; i < 2; i++) begin
         csr_psel <= 1'b1;
         csr_pwrite <= 1'b1;
         csr_penable <= 1'b0;
         csr_paddr <= (i == 0) ? KEY_HIGH_ADDR : KEY_LOW_ADDR;
         csr_pwdata <= (i == 0) ? hi : lo;
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      key_loads++;
   endtask

   // Encrypt a message, collect ciphertext and tag, then decrypt it under the same nonce
   // and associated data with that tag, so the tag compare comes out true; now and then
   // flip one tag bit to see the mismatch side as well.
   task automatic round_trip();
      logic [63:0] nonce_a, nonce_b, tag_a, tag_b;
      logic [63:0] ad_words[$];
      logic [63:0] plain[$];
      logic [63:0] cipher[$];
      int          n_ad, n_blk;
      n_ad = $urandom_range(0, 3);
      n_blk = $urandom_range(0, 4);
      nonce_a = rand_word();
      nonce_b = rand_word();
      for (int i = 0; i < n_ad; i++) begin
         ad_words.push_back(rand_word());
      end
      for (int i = 0; i < n_blk; i++) begin
         plain.push_back(rand_word());
      end
      drain(1'b0);
      seen_blocks.delete();
      send_item(CMD_INIT, nonce_a, nonce_b);
      foreach (ad_words[i]) send_item(CMD_ASSOC, ad_words[i], rand_word());
      foreach (plain[i]) send_item(CMD_ENCRYPT, plain[i], rand_word());
      send_item(CMD_FINALIZE, rand_word(), rand_word());
      // pause the sender until ciphertext and tag are all back
      drain(1'b0);
      cipher = seen_blocks;
      {tag_a, tag_b} = seen_tag;
      if ($urandom_range(0, 3) == 0) begin
         if ($urandom_range(0, 1) == 0) begin
            tag_a[$urandom_range(0, 63)] ^= 1'b1;
         end else begin
            tag_b[$urandom_range(0, 63)] ^= 1'b1;
         end
      end
      send_item(CMD_INIT, nonce_a, nonce_b);
      foreach (ad_words[i]) send_item(CMD_ASSOC, ad_words[i], rand_word());
      foreach (cipher[i]) send_item(CMD_DECRYPT, cipher[i], rand_word());
      send_item(CMD_FINALIZE, tag_a, tag_b);
   endtask

   // Response sink: random stall before each transaction, with two long hold-offs so
   // the core backs up and stalls its request side. Keep data blocks and the last tag
   // for the round trips.
   initial begin
      int n;
      wait (reset == 1'b0);
      forever begin
         if (taken == 200 || taken == 700) begin
            n = LONG_HOLD;
         end else begin
            n = pick_gap();
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         if (rsp_out_kind == KIND_TAG) begin
            seen_tag = {rsp_out_word_a, rsp_out_word_b};
            if (rsp_tag_match) begin
               tag_hits++;
            end
         end else begin
            seen_blocks.push_back(rsp_out_word_a);
         end
      end
   end

   // Request stimulus and verdict.
   initial begin
      int          pick, n_ad, n_blk;
      logic [2:0]  c;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      load_key(rand_word(), rand_word());

      // Directed: work on the zero state before any init, every command, word extremes,
      // associated data after the phase has closed, unknown codes, work after finalize,
      // finalize straight after init.
      send_item(CMD_ENCRYPT, '0, '1);
      send_item(CMD_FINALIZE, '0, '0);
      send_item(CMD_INIT, '0, '0);
      send_item(CMD_ASSOC, '1, '0);
      send_item(CMD_ASSOC, rand_word(), rand_word());
      send_item(CMD_ENCRYPT, '1, '1);
      send_item(CMD_DECRYPT, '0, '1);
      send_item(CMD_ENCRYPT, rand_word(), rand_word());
      send_item(CMD_ASSOC, rand_word(), rand_word());
      for (int k = int'(CMD_FINALIZE) + 1; k <= int'(CMD_LAST_CODE); k++) begin
         send_item(3'(k), '1, '1);
      end
      send_item(CMD_FINALIZE, rand_word(), rand_word());
      send_item(CMD_ENCRYPT, rand_word(), '0);
      send_item(CMD_FINALIZE, '1, '1);
      send_item(CMD_INIT, '1, '1);
      send_item(CMD_FINALIZE, '1, '0);
      send_item(CMD_INIT, rand_word(), rand_word());
      send_item(CMD_DECRYPT, '1, '0);
      send_item(CMD_FINALIZE, '0, '1);

      // Random: one key setting per phase, extremes first. Most traffic is well-formed
      // sessions with random content; the rest is broken sessions and noise.
      sent = 0;
      for (int phase = 0; phase < PHASES; phase++) begin
         drain(1'b1);
         case (phase)
            0: begin
               load_key('0, '0);
            end
            1: begin
               load_key('1, '1);
            end
            2: begin
               load_key('1, '0);
            end
            3: begin
               load_key('0, '1);
            end
            default: begin
               load_key({$urandom, $urandom}, {$urandom, $urandom});
            end
         endcase
         calm = (phase == 2);
         round_trip();
         while (sent < (phase + 1) * PHASE_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 4) begin
               round_trip();
            end else if (pick < 17) begin
               // session, sometimes missing its init
               n_ad = $urandom_range(0, 3);
               n_blk = $urandom_range(0, 5);
               if ($urandom_range(0, 7) != 0) begin
                  send_item(CMD_INIT, rand_word(), rand_word());
               end
               repeat (n_ad) send_item(CMD_ASSOC, rand_word(), rand_word());
               repeat (n_blk) begin
                  c = ($urandom_range(0, 1) == 0) ? CMD_ENCRYPT : CMD_DECRYPT;
                  send_item(c, rand_word(), rand_word());
               end
               send_item(CMD_FINALIZE, rand_word(), rand_word());
            end else begin
               // noise: any code, unknown ones included
               repeat ($urandom_range(1, 6)) begin
                  send_item(3'($urandom_range(0, int'(CMD_LAST_CODE))), rand_word(),
                            rand_word());
               end
            end
         end
      end
      drain(1'b1);

      $display("Sent %0d request transactions under %0d key settings; took %0d responses,",
               sent_total, key_loads, taken);
      $display("%0d with a matching tag, across two hold-offs of %0d cycles", tag_hits,
               LONG_HOLD);
      if (mismatches == 0 && awaiting == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
